[src/pref_pkg.sv]
package pref_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam int FILL_W = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] KIND_CONST = 2'd0;
    localparam logic [1:0] KIND_LOC   = 2'd1;
    localparam logic [1:0] KIND_DEFER = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    localparam logic [4:0] OP_PUSHC  = 5'd0;
    localparam logic [4:0] OP_PUSHL  = 5'd1;
    localparam logic [4:0] OP_NOT    = 5'd2;
    localparam logic [4:0] OP_NEG    = 5'd3;
    localparam logic [4:0] OP_INV    = 5'd4;
    localparam logic [4:0] OP_POW    = 5'd5;
    localparam logic [4:0] OP_MUL    = 5'd6;
    localparam logic [4:0] OP_DIV    = 5'd7;
    localparam logic [4:0] OP_MOD    = 5'd8;
    localparam logic [4:0] OP_SHR    = 5'd9;
    localparam logic [4:0] OP_SHL    = 5'd10;
    localparam logic [4:0] OP_ADD    = 5'd11;
    localparam logic [4:0] OP_SUB    = 5'd12;
    localparam logic [4:0] OP_AND    = 5'd13;
    localparam logic [4:0] OP_OR     = 5'd14;
    localparam logic [4:0] OP_XOR    = 5'd15;
    localparam logic [4:0] OP_EQ     = 5'd16;
    localparam logic [4:0] OP_SGT    = 5'd17;
    localparam logic [4:0] OP_SLT    = 5'd18;
    localparam logic [4:0] OP_UGT    = 5'd19;
    localparam logic [4:0] OP_ULT    = 5'd20;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_DECIDE,
        ST_ITER,
        ST_WRITE,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [1:0]  mode;   // 0 div/mod, 1 pow
        logic [31:0] a;
        logic [31:0] b;
    } iter_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
        logic [31:0] pw;
    } iter_rsp_t;

endpackage

[src/pref_iter.sv]
module pref_iter (
    input  logic                clk,
    input  logic                rst_n,
    input  pref_pkg::iter_cmd_t cmd,
    output pref_pkg::iter_rsp_t rsp
);
    import pref_pkg::*;

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        mode_reg, mode_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] trial;
    logic [31:0] mul_a, mul_b, mul_p;

    assign trial = {r_reg, x_reg[31]} - {1'b0, y_reg};
    // pow: even count acc*=base, odd count base*=base
    assign mul_a = cnt_reg[0] ? x_reg : q_reg;
    assign mul_b = x_reg;
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        mode_next = mode_reg;
        x_next = x_reg;
        y_next = y_reg;
        r_next = r_reg;
        q_next = q_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            mode_next = cmd.mode[0];
            x_next = cmd.a;
            y_next = cmd.b;
            r_next = 32'd0;
            q_next = cmd.mode[0] ? 32'd1 : 32'd0;
            cnt_next = 6'd0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (!mode_reg)
            begin
                x_next = {x_reg[30:0], 1'b0};
                if (!trial[32])
                begin
                    r_next = trial[31:0];
                    q_next = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = {r_reg[30:0], x_reg[31]};
                    q_next = {q_reg[30:0], 1'b0};
                end
                if (cnt_reg == 6'd31)
                    busy_next = 1'b0;
            end
            else
            begin
                if (!cnt_reg[0])
                begin
                    if (y_reg[0])
                        q_next = mul_p;
                end
                else
                begin
                    x_next = mul_p;
                    y_next = {1'b0, y_reg[31:1]};
                end
                if (cnt_reg == 6'd63)
                    busy_next = 1'b0;
            end
        end
    end

    // pow: the acc multiply with the old base comes before the base is squared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        x_reg <= x_next;
        y_reg <= y_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    logic busy_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_d_reg <= 1'b0;
        else
            busy_d_reg <= busy_reg;
    end

    assign rsp.done = busy_d_reg & ~busy_reg;
    assign rsp.quo = q_reg;
    assign rsp.rem = r_reg;
    assign rsp.pw = q_reg;

endmodule

[src/postfix_relocation_expression_folder.sv]
// div/mod with a nonzero divisor and pow are folded by the shared iterative
// divide/multiply unit (one bit or half bit per cycle). The last token adds an
// output walk with one RAM read per stack entry (EMIT_RD, then EMIT).
// busy is high while an item is in work; results appear as one-cycle strobes
// that the receiver cannot stall. rst_n clears control state asynchronously.
module postfix_relocation_expression_folder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic [4:0]  opcode,
    input  logic [31:0] operand_value,
    input  logic [7:0]  operand_section,
    input  logic        last_token,
    output logic        result_valid,
    output logic [1:0]  entry_kind,
    output logic [31:0] entry_value,
    output logic [7:0]  entry_section,
    output logic        is_last_entry,
    output logic        single_value,
    output logic        folded_any,
    output logic        stack_overflowed
);
    import pref_pkg::*;

    logic [41:0] mem [STACK_DEPTH];

    state_t state_reg, state_next;
    logic             lav_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic             fold_reg, fold_next;
    logic             ovf_reg, ovf_next;
    logic [4:0]       op_reg;
    logic [31:0]      val_reg;
    logic [7:0]       sec_reg;
    logic             last_reg;
    logic [41:0]      ea_reg, eb_reg, rd_data;
    logic [SP_W-1:0]  rd_addr;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic             single_reg, single_next;
    logic [41:0]      wr_data_reg, wr_data_next;
    logic [SP_W-1:0]  wr_addr_reg, wr_addr_next;
    logic             wr_en_reg, wr_en_next;
    iter_cmd_t        icmd;
    iter_rsp_t        irsp;
    logic [31:0]      res;
    logic             do_write, do_rd;

    pref_iter u_iter (.clk(clk), .rst_n(rst_n), .cmd(icmd), .rsp(irsp));

    logic [1:0]  ka, kb;
    logic [31:0] va, vb;
    logic [7:0]  sa, sb;
    assign ka = ea_reg[41:40];
    assign va = ea_reg[39:8];
    assign sa = ea_reg[7:0];
    assign kb = eb_reg[41:40];
    assign vb = eb_reg[39:8];
    assign sb = eb_reg[7:0];

    always_comb
    begin
        case (op_reg)
            OP_MUL: res = va * vb;
            OP_SHR: res = (vb >= 32'd32) ? 32'd0 : (va >> vb[4:0]);
            OP_SHL: res = (vb >= 32'd32) ? 32'd0 : (va << vb[4:0]);
            OP_ADD: res = va + vb;
            OP_SUB: res = va - vb;
            OP_AND: res = va & vb;
            OP_OR:  res = va | vb;
            OP_XOR: res = va ^ vb;
            OP_EQ:  res = {31'd0, va == vb};
            OP_SGT: res = {31'd0, $signed(va) > $signed(vb)};
            OP_SLT: res = {31'd0, $signed(va) < $signed(vb)};
            OP_UGT: res = {31'd0, va > vb};
            default: res = {31'd0, va < vb};
        endcase
    end

    // top entry is still on rd_data during DECIDE
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_RD1;
            ST_RD1: state_next = ST_RD2;
            ST_RD2: state_next = ST_DECIDE;
            ST_DECIDE:
                if ((op_reg == OP_DIV || op_reg == OP_MOD || op_reg == OP_POW)
                    && fill_reg >= FILL_W'(2) && ka == KIND_CONST
                    && rd_data[41:40] == KIND_CONST
                    && !(op_reg != OP_POW && rd_data[39:8] == 32'd0))
                    state_next = ST_ITER;
                else
                    state_next = ST_WRITE;
            ST_ITER:
                if (irsp.done)
                    state_next = ST_WRITE;
            ST_WRITE: state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
            ST_EMIT_RD: state_next = ST_EMIT;
            ST_EMIT:
                if (idx_reg + FILL_W'(1) >= fill_reg)
                    state_next = ST_IDLE;
                else
                    state_next = ST_EMIT_RD;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        fold_next = fold_reg;
        ovf_next = ovf_reg;
        idx_next = idx_reg;
        single_next = single_reg;
        wr_en_next = 1'b0;
        wr_data_next = wr_data_reg;
        wr_addr_next = wr_addr_reg;
        rd_addr = SP_W'(fill_reg - FILL_W'(1));
        do_rd = 1'b0;
        icmd.start = 1'b0;
        icmd.mode = (op_reg == OP_POW) ? 2'd1 : 2'd0;
        icmd.a = va;
        icmd.b = rd_data[39:8];
        result_valid = 1'b0;
        do_write = 1'b0;
        case (state_reg)
            ST_RD1:
            begin
                do_rd = 1'b1;
                rd_addr = SP_W'(fill_reg - FILL_W'(2));
            end
            ST_RD2:
            begin
                do_rd = 1'b1;
                rd_addr = SP_W'(fill_reg - FILL_W'(1));
            end
            ST_DECIDE:
                icmd.start = (state_next == ST_ITER);
            ST_WRITE:
            begin
                do_write = 1'b1;
                idx_next = '0;
                if (op_reg == OP_PUSHC || op_reg == OP_PUSHL ||
                    ((op_reg == OP_NOT || op_reg == OP_NEG || op_reg == OP_INV) &&
                     !(fill_reg >= FILL_W'(1) && kb == KIND_CONST)) ||
                    (op_reg >= OP_POW && op_reg <= OP_ULT))
                begin
                    // push path, or binary fold into slot fill-2
                    if (op_reg == OP_PUSHC || (op_reg == OP_PUSHL && lav_reg))
                        wr_data_next = {KIND_CONST, val_reg, 8'd0};
                    else if (op_reg == OP_PUSHL)
                        wr_data_next = {KIND_LOC, val_reg, sec_reg};
                    else
                        wr_data_next = {KIND_DEFER, 27'd0, op_reg, 8'd0};
                    wr_addr_next = SP_W'(fill_reg);
                    if (op_reg >= OP_POW && fill_reg >= FILL_W'(2))
                    begin
                        wr_addr_next = SP_W'(fill_reg - FILL_W'(2));
                        if (ka == KIND_CONST && kb == KIND_CONST)
                        begin
                            fold_next = 1'b1;
                            fill_next = fill_reg - FILL_W'(1);
                            wr_en_next = 1'b1;
                            if (op_reg == OP_POW)
                                wr_data_next = {KIND_CONST, irsp.pw, 8'd0};
                            else if (op_reg == OP_DIV)
                                wr_data_next = {KIND_CONST,
                                    (vb == 32'd0) ? 32'hFFFFFFFF : irsp.quo, 8'd0};
                            else if (op_reg == OP_MOD)
                                wr_data_next = {KIND_CONST,
                                    (vb == 32'd0) ? va : irsp.rem, 8'd0};
                            else
                                wr_data_next = {KIND_CONST, res, 8'd0};
                        end
                        else if (ka == KIND_CONST && kb == KIND_LOC && op_reg == OP_ADD)
                        begin
                            fold_next = 1'b1;
                            fill_next = fill_reg - FILL_W'(1);
                            wr_en_next = 1'b1;
                            wr_data_next = {KIND_LOC, va + vb, sb};
                        end
                        else if (ka == KIND_LOC && kb == KIND_CONST &&
                                 (op_reg == OP_ADD || op_reg == OP_SUB))
                        begin
                            fold_next = 1'b1;
                            fill_next = fill_reg - FILL_W'(1);
                            wr_en_next = 1'b1;
                            wr_data_next = {KIND_LOC,
                                (op_reg == OP_ADD) ? va + vb : va - vb, sa};
                        end
                        else if (ka == KIND_LOC && kb == KIND_LOC && sa == sb &&
                                 (op_reg == OP_SUB || op_reg >= OP_EQ))
                        begin
                            fold_next = 1'b1;
                            fill_next = fill_reg - FILL_W'(1);
                            wr_en_next = 1'b1;
                            if (op_reg == OP_SUB)
                                wr_data_next = {KIND_CONST, va - vb, 8'd0};
                            else if (op_reg == OP_EQ)
                                wr_data_next = {KIND_CONST, 31'd0, va == vb, 8'd0};
                            else if (op_reg == OP_SGT || op_reg == OP_UGT)
                                wr_data_next = {KIND_CONST, 31'd0, va > vb, 8'd0};
                            else
                                wr_data_next = {KIND_CONST, 31'd0, va < vb, 8'd0};
                        end
                        else
                            wr_addr_next = SP_W'(fill_reg);
                    end
                    if (!wr_en_next)
                    begin
                        if (fill_reg >= FILL_W'(STACK_DEPTH))
                            ovf_next = 1'b1;
                        else
                        begin
                            wr_en_next = 1'b1;
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end
                end
                else if (op_reg == OP_NOT || op_reg == OP_NEG || op_reg == OP_INV)
                begin
                    fold_next = 1'b1;
                    wr_en_next = 1'b1;
                    wr_addr_next = SP_W'(fill_reg - FILL_W'(1));
                    if (op_reg == OP_NOT)
                        wr_data_next = {KIND_CONST, 31'd0, vb == 32'd0, sb};
                    else if (op_reg == OP_NEG)
                        wr_data_next = {KIND_CONST, 32'd0 - vb, sb};
                    else
                        wr_data_next = {KIND_CONST, ~vb, sb};
                end
            end
            ST_EMIT_RD:
            begin
                do_rd = 1'b1;
                rd_addr = SP_W'(idx_reg);
                if (idx_reg == '0)
                    single_next = 1'b1;
            end
            ST_EMIT:
            begin
                result_valid = 1'b1;
                idx_next = idx_reg + FILL_W'(1);
                if (state_next == ST_IDLE)
                begin
                    fill_next = '0;
                    fold_next = 1'b0;
                    ovf_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // a pending write may meet a read of the same address; the read path forwards it
    logic [41:0] rd_raw;
    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
            mem[wr_addr_reg] <= wr_data_reg;
        rd_raw <= mem[rd_addr];
    end
    logic fwd_reg;
    logic [41:0] fwd_data_reg;
    always_ff @(posedge clk)
    begin
        fwd_reg <= wr_en_reg && (wr_addr_reg == rd_addr);
        fwd_data_reg <= wr_data_reg;
    end
    assign rd_data = fwd_reg ? fwd_data_reg : rd_raw;

    logic rd1_d_reg, rd2_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lav_reg <= 1'b0;
            fill_reg <= '0;
            fold_reg <= 1'b0;
            ovf_reg <= 1'b0;
            wr_en_reg <= 1'b0;
            idx_reg <= '0;
            rd1_d_reg <= 1'b0;
            rd2_d_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                lav_reg <= cfg_wdata;
            fill_reg <= fill_next;
            fold_reg <= fold_next;
            ovf_reg <= ovf_next;
            wr_en_reg <= wr_en_next;
            idx_reg <= idx_next;
            rd1_d_reg <= (state_reg == ST_RD1);
            rd2_d_reg <= (state_reg == ST_RD2);
        end
    end

    logic [41:0] em_reg;
    always_ff @(posedge clk)
    begin
        wr_data_reg <= wr_data_next;
        wr_addr_reg <= wr_addr_next;
        single_reg <= single_next;
        if (state_reg == ST_IDLE && start)
        begin
            op_reg <= opcode;
            val_reg <= operand_value;
            sec_reg <= operand_section;
            last_reg <= last_token;
        end
        if (rd1_d_reg)
            ea_reg <= rd_data;
        if (rd2_d_reg)
            eb_reg <= rd_data;
    end

    // single: one entry, a constant; computed from the first emitted read
    logic [1:0] kind0;
    assign kind0 = rd_data[41:40];
    always_comb
    begin
        em_reg = rd_data;
    end

    logic single_q_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && idx_reg == '0)
            single_q_reg <= (fill_reg == FILL_W'(1)) && (kind0 == KIND_CONST);
    end

    logic empty;
    assign empty = (fill_reg == '0);
    assign busy = (state_reg != ST_IDLE);
    assign entry_kind = empty ? KIND_EMPTY : em_reg[41:40];
    assign entry_value = empty ? 32'd0 : em_reg[39:8];
    assign entry_section = empty ? 8'd0 : em_reg[7:0];
    assign is_last_entry = empty || (idx_reg + FILL_W'(1) >= fill_reg);
    assign single_value = single_reg && !empty && (fill_reg == FILL_W'(1))
                          && (kind0 == KIND_CONST);
    assign folded_any = fold_reg;
    assign stack_overflowed = ovf_reg;

    logic unused;
    assign unused = do_write ^ do_rd ^ single_q_reg;

endmodule

[dv/tb_postfix_relocation_expression_folder.sv]
`timescale 1ns / 1ps

module tb_postfix_relocation_expression_folder;
    import pref_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [7:0]  section;
        logic        last;
        logic        single;
        logic        folded;
        logic        ovf;
    } entry_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_we;
    logic        cfg_wdata;
    logic [4:0]  opcode;
    logic [31:0] operand_value;
    logic [7:0]  operand_section;
    logic        last_token;
    logic        result_valid;
    logic [1:0]  entry_kind;
    logic [31:0] entry_value;
    logic [7:0]  entry_section;
    logic        is_last_entry;
    logic        single_value;
    logic        folded_any;
    logic        stack_overflowed;

    postfix_relocation_expression_folder uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .opcode(opcode), .operand_value(operand_value),
        .operand_section(operand_section), .last_token(last_token),
        .result_valid(result_valid), .entry_kind(entry_kind),
        .entry_value(entry_value), .entry_section(entry_section),
        .is_last_entry(is_last_entry), .single_value(single_value),
        .folded_any(folded_any), .stack_overflowed(stack_overflowed)
    );

    // predictor state
    logic        loc_as_val;
    logic [1:0]  stk_kind [STACK_DEPTH];
    logic [31:0] stk_value [STACK_DEPTH];
    logic [7:0]  stk_section [STACK_DEPTH];
    int          fill;
    logic        folded;
    logic        ovf;

    entry_t      pending_entries [$];
    int          errors;
    int          idle_cycles;
    int          tok_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_postfix_relocation_expression_folder: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        entry_t e;
        if (rst_n && result_valid)
        begin
            if (pending_entries.size() == 0)
            begin
                $error("unexpected transfer kind=%0d value=%h", entry_kind, entry_value);
                errors++;
            end
            else
            begin
                e = pending_entries.pop_front();
                if (entry_kind !== e.kind)
                begin
                    $error("entry_kind exp %0d got %0d", e.kind, entry_kind);
                    errors++;
                end
                if (entry_value !== e.value)
                begin
                    $error("entry_value exp %h got %h", e.value, entry_value);
                    errors++;
                end
                if (entry_section !== e.section)
                begin
                    $error("entry_section exp %h got %h", e.section, entry_section);
                    errors++;
                end
                if (is_last_entry !== e.last)
                begin
                    $error("is_last_entry exp %0d got %0d", e.last, is_last_entry);
                    errors++;
                end
                if (single_value !== e.single)
                begin
                    $error("single_value exp %0d got %0d", e.single, single_value);
                    errors++;
                end
                if (folded_any !== e.folded)
                begin
                    $error("folded_any exp %0d got %0d", e.folded, folded_any);
                    errors++;
                end
                if (stack_overflowed !== e.ovf)
                begin
                    $error("stack_overflowed exp %0d got %0d", e.ovf, stack_overflowed);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] power32(logic [31:0] b, logic [31:0] x);
        logic [31:0] acc;
        acc = 32'd1;
        while (x != 0)
        begin
            if (x[0])
                acc = acc * b;
            b = b * b;
            x = x >> 1;
        end
        return acc;
    endfunction

    function automatic logic [31:0] fold_consts(logic [4:0] op, logic [31:0] x,
                                                logic [31:0] y);
        case (op)
            OP_POW: return power32(x, y);
            OP_MUL: return x * y;
            OP_DIV: return (y == 0) ? 32'hFFFF_FFFF : x / y;
            OP_MOD: return (y == 0) ? x : x % y;
            OP_SHR: return (y >= 32) ? 32'd0 : x >> y[4:0];
            OP_SHL: return (y >= 32) ? 32'd0 : x << y[4:0];
            OP_ADD: return x + y;
            OP_SUB: return x - y;
            OP_AND: return x & y;
            OP_OR:  return x | y;
            OP_XOR: return x ^ y;
            OP_EQ:  return {31'd0, x == y};
            OP_SGT: return {31'd0, $signed(x) > $signed(y)};
            OP_SLT: return {31'd0, $signed(x) < $signed(y)};
            OP_UGT: return {31'd0, x > y};
            default: return {31'd0, x < y};
        endcase
    endfunction

    task automatic stack_push(logic [1:0] k, logic [31:0] v, logic [7:0] s);
        if (fill >= STACK_DEPTH)
            ovf = 1'b1;
        else
        begin
            stk_kind[fill] = k;
            stk_value[fill] = v;
            stk_section[fill] = s;
            fill++;
        end
    endtask

    function automatic bit fold_binary(logic [4:0] op);
        int ia;
        logic [1:0] ka, kb;
        logic [31:0] va, vb, r;
        if (fill < 2)
            return 0;
        ia = fill - 2;
        ka = stk_kind[ia];
        kb = stk_kind[ia + 1];
        va = stk_value[ia];
        vb = stk_value[ia + 1];
        if (ka == KIND_CONST && kb == KIND_CONST)
        begin
            stk_value[ia] = fold_consts(op, va, vb);
            stk_section[ia] = 8'd0;
        end
        else if (ka == KIND_CONST && kb == KIND_LOC && op == OP_ADD)
        begin
            stk_kind[ia] = KIND_LOC;
            stk_value[ia] = va + vb;
            stk_section[ia] = stk_section[ia + 1];
        end
        else if (ka == KIND_LOC && kb == KIND_CONST && (op == OP_ADD || op == OP_SUB))
            stk_value[ia] = (op == OP_ADD) ? va + vb : va - vb;
        else if (ka == KIND_LOC && kb == KIND_LOC && stk_section[ia] == stk_section[ia + 1])
        begin
            if (op == OP_SUB) r = va - vb;
            else if (op == OP_EQ) r = {31'd0, va == vb};
            else if (op == OP_SGT || op == OP_UGT) r = {31'd0, va > vb};
            else if (op == OP_SLT || op == OP_ULT) r = {31'd0, va < vb};
            else return 0;
            stk_kind[ia] = KIND_CONST;
            stk_value[ia] = r;
            stk_section[ia] = 8'd0;
        end
        else
            return 0;
        fill = ia + 1;
        return 1;
    endfunction

    task automatic predict_token(logic [4:0] op, logic [31:0] v, logic [7:0] s, logic lst);
        entry_t e;
        logic [31:0] t;
        logic sgl;
        if (op == OP_PUSHC)
            stack_push(KIND_CONST, v, 8'd0);
        else if (op == OP_PUSHL)
        begin
            if (loc_as_val) stack_push(KIND_CONST, v, 8'd0);
            else stack_push(KIND_LOC, v, s);
        end
        else if (op <= OP_INV)
        begin
            if (fill >= 1 && stk_kind[fill - 1] == KIND_CONST)
            begin
                t = stk_value[fill - 1];
                if (op == OP_NOT) t = (t == 0) ? 32'd1 : 32'd0;
                else if (op == OP_NEG) t = 32'd0 - t;
                else t = ~t;
                stk_value[fill - 1] = t;
                folded = 1'b1;
            end
            else
                stack_push(KIND_DEFER, {27'd0, op}, 8'd0);
        end
        else if (op <= OP_ULT)
        begin
            if (fold_binary(op)) folded = 1'b1;
            else stack_push(KIND_DEFER, {27'd0, op}, 8'd0);
        end
        if (!lst)
            return;
        sgl = (fill == 1 && stk_kind[0] == KIND_CONST);
        if (fill == 0)
        begin
            e = '{KIND_EMPTY, 32'd0, 8'd0, 1'b1, 1'b0, folded, ovf};
            pending_entries.push_back(e);
        end
        for (int i = 0; i < fill; i++)
        begin
            e = '{stk_kind[i], stk_value[i], stk_section[i], i + 1 == fill, sgl, folded, ovf};
            pending_entries.push_back(e);
        end
        fill = 0;
        folded = 1'b0;
        ovf = 1'b0;
    endtask

    int burst_left;

    task automatic send_token(logic [4:0] op, logic [31:0] v, logic [7:0] s, logic lst);
        if (burst_left <= 0)
        begin
            repeat ($urandom_range(6, 0)) @(negedge clk);
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        while (busy) @(negedge clk);
        opcode <= op;
        operand_value <= v;
        operand_section <= s;
        last_token <= lst;
        start <= 1'b1;
        @(posedge clk);
        predict_token(op, v, s, lst);
        tok_count++;
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic drain;
        while (pending_entries.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_cfg(logic val);
        drain();
        cfg_wdata <= val;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        loc_as_val = val;
    endtask

    task automatic test_empty_and_unknown;
        send_token(5'd25, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_token(5'd31, 32'd0, 8'd0, 1'b0);
        send_token(OP_ADD, 32'd0, 8'd0, 1'b1);
    endtask

    task automatic test_const_extremes;
        send_token(OP_PUSHC, 32'hFFFF_FFFF, 8'hFF, 1'b0);
        send_token(OP_PUSHC, 32'd0, 8'd0, 1'b0);
        send_token(OP_DIV, 32'd0, 8'd0, 1'b0);
        send_token(OP_PUSHC, 32'd0, 8'd0, 1'b0);
        send_token(OP_MOD, 32'd0, 8'd0, 1'b0);
        send_token(OP_PUSHC, 32'd40, 8'd0, 1'b0);
        send_token(OP_SHL, 32'd0, 8'd0, 1'b0);
        send_token(OP_NOT, 32'd0, 8'd0, 1'b0);
        send_token(OP_NEG, 32'd0, 8'd0, 1'b0);
        send_token(OP_PUSHC, 32'hFFFF_FFFF, 8'd0, 1'b0);
        send_token(OP_POW, 32'd0, 8'd0, 1'b1);
    endtask

    task automatic test_locations;
        send_token(OP_PUSHL, 32'h100, 8'd7, 1'b0);
        send_token(OP_PUSHL, 32'h40, 8'd7, 1'b0);
        send_token(OP_SUB, 32'd0, 8'd0, 1'b0);
        send_token(OP_PUSHL, 32'h8, 8'hFF, 1'b0);
        send_token(OP_ADD, 32'd0, 8'd0, 1'b0);
        send_token(OP_PUSHL, 32'h8, 8'd1, 1'b0);
        send_token(OP_SUB, 32'd0, 8'd0, 1'b0);
        send_token(OP_INV, 32'd0, 8'd0, 1'b1);
    endtask

    task automatic test_overflow;
        for (int i = 0; i < STACK_DEPTH + 2; i++)
            send_token(OP_PUSHL, $urandom, 8'($urandom), 1'b0);
        send_token(OP_MUL, 32'd0, 8'd0, 1'b1);
    endtask

    task automatic random_expression(int n);
        logic [4:0] op;
        logic [31:0] v;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 40) op = 5'($urandom_range(1, 0));
            else if (r < 97) op = 5'($urandom_range(20, 2));
            else op = 5'($urandom_range(31, 21));
            case ($urandom_range(3))
                0: v = $urandom_range(40);
                1: v = {$urandom_range(1) ? 32'hFFFF_FFFF : 32'd0};
                default: v = $urandom;
            endcase
            send_token(op, v,
                       8'($urandom_range(1) ? $urandom_range(2) : $urandom_range(255)),
                       i == n - 1);
        end
    endtask

    task automatic test_random(int target);
        while (tok_count < target)
        begin
            if ($urandom_range(9) == 0) random_expression($urandom_range(20, 1));
            else random_expression($urandom_range(6, 1));
            if ($urandom_range(29) == 0) drain();
        end
    endtask

    initial
    begin
        errors = 0;
        tok_count = 0;
        burst_left = 0;
        loc_as_val = 1'b0;
        fill = 0;
        folded = 1'b0;
        ovf = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        opcode = '0;
        operand_value = '0;
        operand_section = '0;
        last_token = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_and_unknown();
        test_const_extremes();
        test_locations();
        test_overflow();
        write_cfg(1'b1);
        test_locations();
        test_random(230);
        write_cfg(1'b0);
        test_random(410);
        drain();
        if (errors == 0)
            $display("tb_postfix_relocation_expression_folder: clean");
        else
            $display("tb_postfix_relocation_expression_folder: errors");
        $finish;
    end

endmodule

[files.f]
src/pref_pkg.sv
src/pref_iter.sv
src/postfix_relocation_expression_folder.sv
dv/tb_postfix_relocation_expression_folder.sv
